/* sv/ek3_pkg.sv */
package ek3_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       end_of_row;
    logic       end_of_frame;
  } out_beat_t;

  // per-beat position decisions, taken when the beat is accepted
  typedef struct packed {
    logic draining;
    logic emit;
    logic eor;
    logic eof;
    logic top_mask;
    logic bot_mask;
    logic left_mask;
    logic col_zero;
  } pos_flags_t;

  typedef logic [1:0] cfg_index_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_index_t REG_KERNEL_SELECT = 2'd0;
  localparam cfg_index_t REG_IMAGE_WIDTH   = 2'd1;
  localparam cfg_index_t REG_IMAGE_HEIGHT  = 2'd2;

  localparam logic [2:0]  KSEL_RESET   = 3'd0;
  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd768;

  localparam int KernelCount = 5;
  localparam int TapCount    = 9;

  typedef logic signed [4:0] coef_t;

  localparam coef_t KERNELS [KernelCount][TapCount] = '{
    '{-5'sd1,  5'sd0,  5'sd1, -5'sd2,  5'sd0,  5'sd2, -5'sd1,  5'sd0,  5'sd1},
    '{-5'sd1, -5'sd2, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd1},
    '{ 5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd0, -5'sd1},
    '{ 5'sd1,  5'sd1,  5'sd1,  5'sd0,  5'sd0,  5'sd0, -5'sd1, -5'sd1, -5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
  };

  // unused select codes give an all-zero kernel
  function automatic coef_t kernel_coef(input logic [2:0] ksel, input logic [3:0] tap);
    coef_t c;
    c = '0;
    if (32'(ksel) < KernelCount && 32'(tap) < TapCount) begin
      c = KERNELS[ksel][tap];
    end
    return c;
  endfunction

endpackage

/* sv/ek3_pos_ctrl.sv */
module ek3_pos_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic                accept,
  input  logic                req_type,
  input  logic [10:0]         image_width,
  input  logic [15:0]         image_height,
  output logic                take,
  output logic [CW-1:0]       col,
  output ek3_pkg::pos_flags_t flags
);
  import ek3_pkg::*;

  localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [16:0]   in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [15:0]   out_row_r, out_row_nxt;

  logic [EW-1:0] w_ext;
  logic [EW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic          col_last;
  logic          draining;
  logic          emit;
  logic          eor;
  logic          eof;

  always_comb begin
    w_ext = EW'(image_width);
    if (image_width == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff    = (image_height == '0) ? 16'd1 : image_height;
    draining = in_row_r >= {1'b0, h_eff};
    emit     = (in_row_r >= 17'd2) || (in_row_r == 17'd1 && in_col_r != '0);
    col_last = (EW'(in_col_r) + EW'(1)) >= w_eff;
    eor      = (EW'(out_col_r) + EW'(1)) >= w_eff;
    eof      = eor && (({1'b0, out_row_r} + 17'd1) >= {1'b0, h_eff});
  end

  assign take = draining || !req_type;
  assign col  = in_col_r;

  always_comb begin
    flags.draining  = draining;
    flags.emit      = emit;
    flags.eor       = eor;
    flags.eof       = eof;
    flags.top_mask  = out_row_r == '0;
    flags.bot_mask  = ({1'b0, out_row_r} + 17'd1) >= {1'b0, h_eff};
    flags.left_mask = out_col_r == '0;
    flags.col_zero  = in_col_r == '0;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (clear) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (accept && take) begin
      if (emit && eof) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (col_last) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + 17'd1;
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
        if (emit) begin
          if (eor) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + 16'd1;
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

/* sv/ek3_line_buf.sv */
module ek3_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_top,
  input  logic [7:0]    wr_mid,
  output logic [7:0]    rd_top,
  output logic [7:0]    rd_mid
);

  logic [7:0] top_mem [DEPTH];
  logic [7:0] mid_mem [DEPTH];

  logic [7:0] top_q_r;
  logic [7:0] mid_q_r;
  logic       fwd_r;
  logic [7:0] fwd_top_r;
  logic [7:0] fwd_mid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[wr_addr] <= wr_top;
      mid_mem[wr_addr] <= wr_mid;
    end
  end

  // read-first memory: a same-address write in the read cycle is bypassed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_q_r   <= top_mem[rd_addr];
      mid_q_r   <= mid_mem[rd_addr];
      fwd_r     <= wr_en && (wr_addr == rd_addr);
      fwd_top_r <= wr_top;
      fwd_mid_r <= wr_mid;
    end
  end

  assign rd_top = fwd_r ? fwd_top_r : top_q_r;
  assign rd_mid = fwd_r ? fwd_mid_r : mid_q_r;

endmodule

/* sv/ek3_filter.sv */
module ek3_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [2:0]          kernel_sel,
  input  logic [7:0]          top_px,
  input  logic [7:0]          mid_px,
  input  logic [7:0]          new_px,
  input  ek3_pkg::pos_flags_t flags,
  output logic [7:0]          result
);
  import ek3_pkg::*;

  logic [7:0]        win_r   [TapCount];
  logic [7:0]        win_nxt [TapCount];
  logic [7:0]        tap     [TapCount];
  logic signed [13:0] prod   [TapCount];
  logic signed [13:0] acc;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3+0] = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = top_px;
    win_nxt[5] = mid_px;
    win_nxt[8] = new_px;
  end

  // taps outside the image read as zero
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && flags.top_mask) || (r == 2 && flags.bot_mask) ||
            (c == 0 && flags.left_mask) ||
            (c == 2 && (flags.eor || flags.col_zero))) begin
          tap[r*3+c] = '0;
        end else begin
          tap[r*3+c] = win_nxt[r*3+c];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < TapCount; i++) begin
      prod[i] = 14'($signed({1'b0, tap[i]}) * kernel_coef(kernel_sel, 4'(i)));
      acc     = acc + prod[i];
    end
    if (acc < 14'sd0) begin
      result = '0;
    end else if (acc > 14'sd255) begin
      result = 8'd255;
    end else begin
      result = acc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TapCount; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < TapCount; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

/* sv/edge_kernel_3x3_convolution_unit.sv */
// a result passes through the stage-1 register and then the output register after the beat that releases it is accepted
// a result belongs to the pixel one row plus one pixel before that beat
// throughput: one beat per cycle unless a held result stalls stage 1 while out_ready is low
// reset: kernel 0, width 1024, height 768, position counters and window cleared
// line buffers are not cleared; taps outside the image are masked instead
module edge_kernel_3x3_convolution_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ek3_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ek3_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  ek3_pkg::cfg_index_t cfg_index,
  input  ek3_pkg::cfg_data_t cfg_data
);
  import ek3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [2:0]  kernel_sel_r;
  logic [10:0] image_width_r;
  logic [15:0] image_height_r;
  logic        cfg_we;
  logic        geom_clear;

  logic        in_accept;
  logic        take;
  logic        load;
  logic [CW-1:0] col;
  pos_flags_t  flags;

  logic          s1_valid_r;
  logic [7:0]    s1_px_r;
  logic [CW-1:0] s1_col_r;
  pos_flags_t    s1_flags_r;
  logic          s1_adv;

  logic [7:0]  top_px;
  logic [7:0]  mid_px;
  logic [7:0]  result;

  logic        out_valid_r;
  out_beat_t   out_data_r;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign geom_clear = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                                 cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_sel_r   <= KSEL_RESET;
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_SELECT: kernel_sel_r   <= cfg_data[2:0];
        REG_IMAGE_WIDTH:   image_width_r  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a beat without a result leaves without the output register
  assign s1_adv    = s1_valid_r && (!s1_flags_r.emit || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign load      = in_accept && take;

  ek3_pos_ctrl #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW(CW)
  ) u_pos_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (geom_clear),
    .accept      (in_accept),
    .req_type    (in_data.req_type),
    .image_width (image_width_r),
    .image_height(image_height_r),
    .take        (take),
    .col         (col),
    .flags       (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_px_r    <= flags.draining ? 8'd0 : in_data.pixel_in;
      s1_col_r   <= col;
      s1_flags_r <= flags;
    end
  end

  ek3_line_buf #(
    .DEPTH(MAX_WIDTH),
    .AW(CW)
  ) u_line_buf (
    .clk    (clk),
    .rd_en  (load),
    .rd_addr(col),
    .wr_en  (s1_adv),
    .wr_addr(s1_col_r),
    .wr_top (mid_px),
    .wr_mid (s1_px_r),
    .rd_top (top_px),
    .rd_mid (mid_px)
  );

  ek3_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .kernel_sel(kernel_sel_r),
    .top_px    (top_px),
    .mid_px    (mid_px),
    .new_px    (s1_px_r),
    .flags     (s1_flags_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_flags_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags_r.emit) begin
      out_data_r.pixel_out    <= result;
      out_data_r.end_of_row   <= s1_flags_r.eor;
      out_data_r.end_of_frame <= s1_flags_r.eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !load)
    else $error("held beat overwritten");

  a_eof_geometry: assert property (@(posedge clk) disable iff (!rst_n)
    (load && flags.emit && flags.eof) |-> (flags.eor && flags.bot_mask))
    else $error("end of frame off the last row or column");

  a_eof_has_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.end_of_frame || out_data_r.end_of_row))
    else $error("end of frame without end of row");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_flags_r.emit) |=> out_valid_r)
    else $error("result beat lost");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ek3_pkg::*;

  localparam int MAX_W = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BEATS = 300;
  localparam int WIDE_BEATS = 40;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [2:0] KS_SOBEL_H   = 3'd0;
  localparam logic [2:0] KS_SOBEL_V   = 3'd1;
  localparam logic [2:0] KS_PREWITT_H = 3'd2;
  localparam logic [2:0] KS_PREWITT_V = 3'd3;
  localparam logic [2:0] KS_LAPLACE   = 3'd4;
  localparam logic [2:0] KS_NONE      = 3'd7;
  localparam int KS_COUNT = 5;

  localparam cfg_index_t REG_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  cfg_data_t cfg_data;

  edge_kernel_3x3_convolution_unit #(
    .MAX_WIDTH(MAX_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  int weights [5][9] = '{
    '{-1,  0,  1, -2,  0,  2, -1,  0,  1},
    '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
    '{ 1,  0, -1,  1,  0, -1,  1,  0, -1},
    '{ 1,  1,  1,  0,  0,  0, -1, -1, -1},
    '{-1, -1, -1, -1,  8, -1, -1, -1, -1}
  };

  logic [2:0]  reg_kernel;
  logic [10:0] reg_width;
  logic [15:0] reg_height;
  logic [7:0]  line_mem [2*MAX_W];
  logic [7:0]  win [9];
  int unsigned in_col, in_row, out_col, out_row;

  out_beat_t filtered_q [$];
  int mismatch_count;
  int cycle_count;
  int gap_pct;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_w();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_W) return MAX_W;
    return reg_width;
  endfunction

  function automatic int unsigned eff_h();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  function automatic void clear_positions();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void convolve_pixel(input in_beat_t b, output bit hit,
                                         output out_beat_t res);
    int unsigned w, h, ic, px;
    logic [7:0] top, mid;
    logic [7:0] taps [9];
    bit draining, emit, eor, eof;
    int acc, r, c;
    hit = 1'b0;
    res = '0;
    w = eff_w();
    h = eff_h();
    draining = in_row >= h;
    if (!draining && b.req_type == REQ_DRAIN) return;
    px = draining ? 0 : b.pixel_in;
    ic = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
    emit = in_row >= 2 || (in_row == 1 && ic >= 1);
    // row start: pending result is the last column, window moved left by one
    if (emit && ic == 0) begin
      for (r = 0; r < 3; r++) begin
        taps[r*3]   = win[r*3+1];
        taps[r*3+1] = win[r*3+2];
        taps[r*3+2] = 8'd0;
      end
    end
    top = line_mem[MAX_W+ic];
    mid = line_mem[ic];
    line_mem[MAX_W+ic] = mid;
    line_mem[ic] = 8'(px);
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = 8'(px);
    if (emit && ic != 0) taps = win;
    if (ic + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = ic + 1;
    end
    if (!emit) return;
    eor = out_col + 1 >= w;
    eof = eor && out_row + 1 >= h;
    acc = 0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if ((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h)) continue;
        if ((c == 0 && out_col == 0) || (c == 2 && eor)) continue;
        if (reg_kernel < KS_COUNT) acc += weights[reg_kernel][r*3+c] * int'(taps[r*3+c]);
      end
    end
    if (acc < 0) acc = 0;
    else if (acc > 255) acc = 255;
    res.pixel_out = 8'(acc);
    res.end_of_row = eor;
    res.end_of_frame = eof;
    if (eof) begin
      clear_positions();
    end else if (eor) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    hit = 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    out_beat_t predicted;
    bit produced;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat pixel %0d eor %0b eof %0b",
                                    out_data.pixel_out, out_data.end_of_row,
                                    out_data.end_of_frame));
        end else begin
          want = filtered_q.pop_front();
          if (out_data.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out %0d, wanted %0d",
                                      out_data.pixel_out, want.pixel_out));
          if (out_data.end_of_row !== want.end_of_row)
            report_mismatch($sformatf("end_of_row %0b, wanted %0b",
                                      out_data.end_of_row, want.end_of_row));
          if (out_data.end_of_frame !== want.end_of_frame)
            report_mismatch($sformatf("end_of_frame %0b, wanted %0b",
                                      out_data.end_of_frame, want.end_of_frame));
        end
      end
      if (in_valid && in_ready) begin
        convolve_pixel(in_data, produced, predicted);
        if (produced) filtered_q.insert(filtered_q.size(), predicted);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERNEL_SELECT: reg_kernel = cfg_data[2:0];
          REG_IMAGE_WIDTH: begin
            reg_width = cfg_data[10:0];
            clear_positions();
          end
          REG_IMAGE_HEIGHT: begin
            reg_height = cfg_data;
            clear_positions();
          end
          default: ;
        endcase
      end
    end
  end

  // result side back-pressure, in stretches of varying density
  initial begin : sink
    int mode;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        @(posedge clk);
        if (!calm && mode != 0 && $urandom_range(0, (mode == 1) ? 11 : 2) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic req, input logic [7:0] px);
    in_beat_t b;
    b.req_type = req;
    b.pixel_in = px;
    if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frame(input int noise_pct, input int switch_at);
    int unsigned w, h;
    int i;
    w = eff_w();
    h = eff_h();
    for (i = 0; i < w * h; i++) begin
      if (i == switch_at) begin
        settle();
        write_reg(REG_KERNEL_SELECT, {13'($urandom), 3'($urandom_range(0, 7))});
      end
      if ($urandom_range(0, 99) < noise_pct) send_pixel(REQ_DRAIN, rand_pixel());
      send_pixel(REQ_PIXEL, rand_pixel());
    end
    for (i = 0; i <= w; i++)
      send_pixel(($urandom_range(0, 3) == 0) ? REQ_PIXEL : REQ_DRAIN, rand_pixel());
  endtask

  task automatic test_reset_defaults();
    int i;
    gap_pct = 20;
    for (i = 0; i < 20; i++) send_pixel(REQ_PIXEL, rand_pixel());
    settle();
  endtask

  task automatic test_directed_edges();
    logic [7:0] px [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
    int i;
    gap_pct = 0;
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    write_reg(REG_KERNEL_SELECT, {13'd0, KS_SOBEL_H});
    for (i = 0; i < 9; i++) begin
      if (i == 4) send_pixel(REQ_DRAIN, 8'hff);
      send_pixel(REQ_PIXEL, px[i]);
    end
    send_pixel(REQ_DRAIN, 8'd0);
    send_pixel(REQ_PIXEL, 8'haa);
    send_pixel(REQ_DRAIN, 8'h55);
    send_pixel(REQ_DRAIN, 8'd0);
    settle();
    // zero width and height, unused kernel code
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    write_reg(REG_KERNEL_SELECT, {13'd0, KS_NONE});
    send_pixel(REQ_PIXEL, 8'd255);
    send_pixel(REQ_DRAIN, 8'd0);
    send_pixel(REQ_DRAIN, 8'd0);
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    write_reg(REG_KERNEL_SELECT, {13'd0, KS_LAPLACE});
    send_pixel(REQ_PIXEL, 8'd255);
    send_pixel(REQ_PIXEL, 8'd0);
    send_pixel(REQ_PIXEL, 8'd0);
    send_pixel(REQ_PIXEL, 8'd255);
    send_pixel(REQ_DRAIN, 8'd0);
    send_pixel(REQ_DRAIN, 8'd0);
    send_pixel(REQ_DRAIN, 8'd0);
    settle();
  endtask

  task automatic test_tall_abandon();
    int i;
    gap_pct = 15;
    write_reg(REG_IMAGE_WIDTH, 16'd1);
    write_reg(REG_IMAGE_HEIGHT, 16'hffff);
    write_reg(REG_KERNEL_SELECT, {13'd0, KS_PREWITT_V});
    for (i = 0; i < 40; i++) send_pixel(REQ_PIXEL, rand_pixel());
    settle();
    for (i = 0; i < 10; i++) send_pixel(REQ_PIXEL, rand_pixel());
    settle();
    write_reg(REG_SPARE, 16'hffff);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    run_frame(10, -1);
    settle();
  endtask

  // partial first rows at full and clamped width, abandoned by the next geometry write
  task automatic test_wide_frames();
    int i;
    gap_pct = 2;
    write_reg(REG_IMAGE_WIDTH, 16'd1024);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    write_reg(REG_KERNEL_SELECT, {13'd0, KS_PREWITT_H});
    for (i = 0; i < WIDE_BEATS; i++) begin
      if (i == 7) send_pixel(REQ_DRAIN, rand_pixel());
      send_pixel(REQ_PIXEL, rand_pixel());
    end
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'hffff);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    write_reg(REG_KERNEL_SELECT, {13'd0, KS_SOBEL_V});
    for (i = 0; i < WIDE_BEATS; i++) send_pixel(REQ_PIXEL, rand_pixel());
    settle();
  endtask

  task automatic test_random_frames();
    int frame_idx, counted, kind, w, h, n, i;
    bit must_restart;
    frame_idx = 0;
    counted = 0;
    must_restart = 1'b1;
    while (counted < RANDOM_BEATS) begin
      settle();
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if (frame_idx < 8 || $urandom_range(0, 2) == 0)
        write_reg(REG_KERNEL_SELECT, {13'($urandom),
                  (frame_idx < 8) ? 3'(frame_idx) : 3'($urandom_range(0, 7))});
      if (must_restart || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = $urandom_range(9, 40);
          default: w = $urandom_range(1, 8);
        endcase
        h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        must_restart = 1'b0;
      end
      n = eff_w() * eff_h();
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
        // broken frame, abandoned by the next geometry write
        for (i = $urandom_range(1, n + eff_w()); i > 0; i--)
          send_pixel(($urandom_range(0, 5) == 0) ? REQ_DRAIN : REQ_PIXEL, rand_pixel());
        counted += n / 2;
        must_restart = 1'b1;
      end else begin
        run_frame(5, (kind == 8) ? $urandom_range(0, n - 1) : -1);
        if (kind == 9)
          for (i = $urandom_range(1, 3); i > 0; i--) send_pixel(REQ_DRAIN, rand_pixel());
        counted += n + eff_w() + 1;
      end
      frame_idx++;
    end
    settle();
  endtask

  task automatic test_back_to_back();
    int k;
    calm = 1'b1;
    gap_pct = 0;
    for (k = 0; k < 5; k++) begin
      settle();
      write_reg(REG_KERNEL_SELECT, {13'd0, 3'(k)});
      write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(1, 12)));
      write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(1, 5)));
      run_frame(0, -1);
    end
  endtask

  initial begin
    int i;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    mismatch_count = 0;
    cycle_count = 0;
    gap_pct = 0;
    calm = 1'b0;
    reg_kernel = KS_SOBEL_H;
    reg_width = 11'd1024;
    reg_height = 16'd768;
    for (i = 0; i < 2 * MAX_W; i++) line_mem[i] = 8'd0;
    for (i = 0; i < 9; i++) win[i] = 8'd0;
    clear_positions();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_edges();
    test_tall_abandon();
    test_wide_frames();
    test_random_frames();
    test_back_to_back();

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
